FILE: src/pstu_pkg.sv
// shared types, register codes and helpers for the particle state update block
package pstu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = 16;

    localparam longint PIHALF_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30    = 64'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_RATE    = 3'd0,
        CFG_SPEED_RATE   = 3'd1,
        CFG_HEADING_RATE = 3'd2,
        CFG_SPIN_RATE    = 3'd3,
        CFG_BIRTH_COLOR  = 3'd4,
        CFG_MIDDLE_COLOR = 3'd5,
        CFG_DEATH_COLOR  = 3'd6
    } t_cfg_idx;

    // particle word after the rate updates
    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] size;
        logic        [15:0] heading;
        logic signed [19:0] speed;
        logic signed [19:0] spin;
        logic        [15:0] age;
        logic        [15:0] life;
        logic               expired;
    } t_motion;

    // one divider stage
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] quo;
        logic [15:0] life;
    } t_div;

    function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
        if (v > 48'sd524287) begin
            return 20'sd524287;
        end else if (v < -48'sd524288) begin
            return -20'sd524288;
        end
        return v[19:0];
    endfunction

endpackage

FILE: src/particle_state_update_top.sv
// particle state update: age, rates, motion from a sine table and color blend, fully pipelined
//
// One particle word is taken on every cycle at which start is high; busy is never raised, so
// the block takes a new word each cycle. Each word comes out on the o_ ports, marked by a
// one-cycle o_valid strobe, in the order the words went in. The result cannot be held off,
// so the receiver must take it in that cycle. The latency is set by the age/lifetime
// divider, which resolves one quotient bit per pipeline stage (16 stages); the motion path
// (rate products, table lookup, step*speed*cos/sin) runs beside it and waits in a delay line.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata and must only
// change while no word is in flight. An expired particle comes out with o_expired set, its
// age and lifetime, and all other fields zero.
module particle_state_update_top #(
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic [11:0]                     i_time_step,
    input  logic signed [19:0]              i_pos_x,
    input  logic signed [19:0]              i_pos_y,
    input  logic signed [19:0]              i_size_now,
    input  logic [15:0]                     i_heading,
    input  logic signed [19:0]              i_speed_now,
    input  logic signed [19:0]              i_spin,
    input  logic [15:0]                     i_age,
    input  logic [15:0]                     i_lifetime,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [pstu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pstu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // result side
    output logic                            o_valid,
    output logic signed [19:0]              o_new_pos_x,
    output logic signed [19:0]              o_new_pos_y,
    output logic signed [19:0]              o_new_size,
    output logic [15:0]                     o_new_heading,
    output logic signed [19:0]              o_new_speed,
    output logic signed [19:0]              o_new_spin,
    output logic [15:0]                     o_new_age,
    output logic [15:0]                     o_lifetime_out,
    output logic [31:0]                     o_color_out,
    output logic                            o_expired
);
    import pstu_pkg::*;

    localparam int IDXW   = $clog2(TRIG_TABLE_DEPTH);
    localparam int LAT    = DIV_STAGES + 5;
    localparam int MDLY   = DIV_STAGES - 2;
    localparam int COSOFF = TRIG_TABLE_DEPTH / 4;

    // sine table, built at elaboration: quarter wave from a Taylor series in Q30
    function automatic longint quarter_sine(input longint m);
        longint theta;
        longint t2;
        longint s;
        theta = (m * PIHALF_Q30) / TRIG_TABLE_DEPTH;
        t2    = (theta * theta) >>> 30;
        s     = ONE_Q30;
        s     = ONE_Q30 - ((t2 * s) >>> 30) / 110;
        s     = ONE_Q30 - ((t2 * s) >>> 30) / 72;
        s     = ONE_Q30 - ((t2 * s) >>> 30) / 42;
        s     = ONE_Q30 - ((t2 * s) >>> 30) / 20;
        s     = ONE_Q30 - ((t2 * s) >>> 30) / 6;
        s     = (theta * s) >>> 30;
        s     = (s + 64'sd32768) >>> 16;
        if (s > 64'sd16384) begin
            s = 64'sd16384;
        end
        return s;
    endfunction

    function automatic longint sine_entry(input longint i);
        longint n4;
        longint q;
        longint r;
        longint v;
        n4 = 4 * i;
        q  = n4 / TRIG_TABLE_DEPTH;
        r  = n4 % TRIG_TABLE_DEPTH;
        unique case (2'(q))
            2'd0: v = quarter_sine(r);
            2'd1: v = quarter_sine(TRIG_TABLE_DEPTH - r);
            2'd2: v = -quarter_sine(r);
            default: v = -quarter_sine(TRIG_TABLE_DEPTH - r);
        endcase
        return v;
    endfunction

    logic signed [15:0] w_sine [TRIG_TABLE_DEPTH];

    for (genvar g = 0; g < TRIG_TABLE_DEPTH; g++) begin : g_rom
        assign w_sine[g] = 16'(sine_entry(g));
    end

    // configuration registers
    logic signed [19:0] r_size_rate;
    logic signed [19:0] r_speed_rate;
    logic signed [23:0] r_heading_rate;
    logic signed [19:0] r_spin_rate;
    logic [31:0]        r_birth_color;
    logic [31:0]        r_middle_color;
    logic [31:0]        r_death_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_rate    <= 20'sd256;
            r_speed_rate   <= '0;
            r_heading_rate <= '0;
            r_spin_rate    <= '0;
            r_birth_color  <= 32'hFFFF_FFFF;
            r_middle_color <= 32'hFFFF_FF80;
            r_death_color  <= 32'hFFFF_FF00;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIZE_RATE:    r_size_rate    <= i_cfg_wdata[19:0];
                CFG_SPEED_RATE:   r_speed_rate   <= i_cfg_wdata[19:0];
                CFG_HEADING_RATE: r_heading_rate <= i_cfg_wdata[23:0];
                CFG_SPIN_RATE:    r_spin_rate    <= i_cfg_wdata[19:0];
                CFG_BIRTH_COLOR:  r_birth_color  <= i_cfg_wdata;
                CFG_MIDDLE_COLOR: r_middle_color <= i_cfg_wdata;
                CFG_DEATH_COLOR:  r_death_color  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // no back pressure anywhere: a word can enter every cycle
    assign busy = 1'b0;

    // valid bits, one per stage
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end

    // stage 1: capture the word
    logic [11:0]        r_s1_dt;
    logic signed [19:0] r_s1_px, r_s1_py, r_s1_sz, r_s1_sp, r_s1_sn;
    logic [15:0]        r_s1_hd, r_s1_age, r_s1_life;

    always_ff @(posedge i_clk) begin
        r_s1_dt   <= i_time_step;
        r_s1_px   <= i_pos_x;
        r_s1_py   <= i_pos_y;
        r_s1_sz   <= i_size_now;
        r_s1_hd   <= i_heading;
        r_s1_sp   <= i_speed_now;
        r_s1_sn   <= i_spin;
        r_s1_age  <= i_age;
        r_s1_life <= i_lifetime;
    end

    // stage 2: new age, expiry, rate times step
    logic [16:0]        w_age_sum;
    logic [15:0]        n_s2_age;
    logic signed [12:0] w_s1_dts;

    assign w_age_sum = {1'b0, r_s1_age} + {5'd0, r_s1_dt};
    assign n_s2_age  = w_age_sum[16] ? 16'hFFFF : w_age_sum[15:0];
    assign w_s1_dts  = $signed({1'b0, r_s1_dt});

    logic [11:0]        r_s2_dt;
    logic signed [19:0] r_s2_px, r_s2_py, r_s2_sz, r_s2_sp, r_s2_sn;
    logic [15:0]        r_s2_hd, r_s2_age, r_s2_life;
    logic               r_s2_exp;
    logic signed [32:0] r_s2_psz, r_s2_psp, r_s2_psn;
    logic signed [36:0] r_s2_phd;

    always_ff @(posedge i_clk) begin
        r_s2_dt   <= r_s1_dt;
        r_s2_px   <= r_s1_px;
        r_s2_py   <= r_s1_py;
        r_s2_sz   <= r_s1_sz;
        r_s2_hd   <= r_s1_hd;
        r_s2_sp   <= r_s1_sp;
        r_s2_sn   <= r_s1_sn;
        r_s2_age  <= n_s2_age;
        r_s2_life <= r_s1_life;
        r_s2_exp  <= (n_s2_age >= r_s1_life);
        r_s2_psz  <= r_size_rate * w_s1_dts;
        r_s2_psp  <= r_speed_rate * w_s1_dts;
        r_s2_psn  <= r_spin_rate * w_s1_dts;
        r_s2_phd  <= r_heading_rate * w_s1_dts;
    end

    // stage 3: round the rate terms, saturating adds, wrapping heading
    logic signed [47:0] w_inc_sz, w_inc_sp, w_inc_sn;
    logic signed [36:0] w_inc_hd;
    t_motion            n_s3_m;

    assign w_inc_sz = (48'(r_s2_psz) + 48'sd2048) >>> 12;
    assign w_inc_sp = (48'(r_s2_psp) + 48'sd2048) >>> 12;
    assign w_inc_sn = (48'(r_s2_psn) + 48'sd2048) >>> 12;
    assign w_inc_hd = (r_s2_phd + 37'sd2048) >>> 12;

    always_comb begin
        n_s3_m         = '0;
        n_s3_m.pos_x   = r_s2_px;
        n_s3_m.pos_y   = r_s2_py;
        n_s3_m.size    = sat20(48'(r_s2_sz) + w_inc_sz);
        n_s3_m.heading = r_s2_hd + w_inc_hd[15:0];
        n_s3_m.speed   = sat20(48'(r_s2_sp) + w_inc_sp);
        n_s3_m.spin    = sat20(48'(r_s2_sn) + w_inc_sn);
        n_s3_m.age     = r_s2_age;
        n_s3_m.life    = r_s2_life;
        n_s3_m.expired = r_s2_exp;
    end

    t_motion     r_s3_m;
    logic [11:0] r_s3_dt;

    always_ff @(posedge i_clk) begin
        r_s3_m  <= n_s3_m;
        r_s3_dt <= r_s2_dt;
    end

    // stage 4: table lookup and speed times step
    logic [31:0]     w_idx_prod;
    logic [IDXW-1:0] w_sin_idx;
    logic [IDXW:0]   w_cos_sum;
    logic [IDXW-1:0] w_cos_idx;

    assign w_idx_prod = 32'(r_s3_m.heading) * 32'(TRIG_TABLE_DEPTH);
    assign w_sin_idx  = w_idx_prod[16 +: IDXW];
    assign w_cos_sum  = {1'b0, w_sin_idx} + (IDXW+1)'(COSOFF);
    assign w_cos_idx  = (w_cos_sum >= (IDXW+1)'(TRIG_TABLE_DEPTH))
                      ? IDXW'(w_cos_sum - (IDXW+1)'(TRIG_TABLE_DEPTH))
                      : w_cos_sum[IDXW-1:0];

    t_motion            r_s4_m;
    logic signed [15:0] r_s4_sin, r_s4_cos;
    logic signed [32:0] r_s4_vdt;

    always_ff @(posedge i_clk) begin
        r_s4_m   <= r_s3_m;
        r_s4_sin <= w_sine[w_sin_idx];
        r_s4_cos <= w_sine[w_cos_idx];
        r_s4_vdt <= r_s3_m.speed * $signed({1'b0, r_s3_dt});
    end

    // stage 5: displacement products
    t_motion            r_s5_m;
    logic signed [48:0] r_s5_xp, r_s5_yp;

    always_ff @(posedge i_clk) begin
        r_s5_m  <= r_s4_m;
        r_s5_xp <= r_s4_vdt * r_s4_cos;
        r_s5_yp <= r_s4_vdt * r_s4_sin;
    end

    // stage 6: round to q12.8 and move
    logic signed [48:0] w_dx, w_dy;
    t_motion            n_s6_m;

    assign w_dx = (r_s5_xp + 49'sd33554432) >>> 26;
    assign w_dy = (r_s5_yp + 49'sd33554432) >>> 26;

    always_comb begin
        n_s6_m       = r_s5_m;
        n_s6_m.pos_x = sat20(48'(r_s5_m.pos_x) + 48'(w_dx));
        n_s6_m.pos_y = sat20(48'(r_s5_m.pos_y) + 48'(w_dy));
    end

    // motion results wait here for the color
    t_motion r_mdly [MDLY+1];

    always_ff @(posedge i_clk) begin
        r_mdly[0] <= n_s6_m;
        for (int k = 1; k <= MDLY; k++) begin
            r_mdly[k] <= r_mdly[k-1];
        end
    end

    // restoring divider for age/lifetime, one quotient bit per stage
    t_div r_dv [DIV_STAGES];

    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        logic [15:0] w_rem_in;
        logic [15:0] w_quo_in;
        logic [15:0] w_life;
        logic [16:0] w_shift;
        logic        w_ge;

        if (d == 0) begin : g_first
            assign w_rem_in = r_s3_m.age;
            assign w_quo_in = '0;
            assign w_life   = r_s3_m.life;
        end else begin : g_next
            assign w_rem_in = r_dv[d-1].rem;
            assign w_quo_in = r_dv[d-1].quo;
            assign w_life   = r_dv[d-1].life;
        end

        assign w_shift = {w_rem_in, 1'b0};
        assign w_ge    = (w_shift >= {1'b0, w_life});

        always_ff @(posedge i_clk) begin
            r_dv[d].rem  <= w_ge ? 16'(w_shift - {1'b0, w_life}) : w_shift[15:0];
            r_dv[d].quo  <= {w_quo_in[14:0], w_ge};
            r_dv[d].life <= w_life;
        end
    end

    // color stage a: pick the half, channel differences times blend factor
    logic [15:0] w_t;
    logic        w_second;
    logic [16:0] w_f;
    logic [31:0] w_ca, w_cb;

    assign w_t      = r_dv[DIV_STAGES-1].quo;
    assign w_second = w_t[15];
    assign w_f      = w_second ? {1'b0, w_t[14:0], 1'b0} : {w_t, 1'b0};
    assign w_ca     = w_second ? r_middle_color : r_birth_color;
    assign w_cb     = w_second ? r_death_color : r_middle_color;

    logic [7:0]         r_c_a  [4];
    logic signed [26:0] r_c_pr [4];

    for (genvar c = 0; c < 4; c++) begin : g_chan
        logic signed [8:0] w_diff;

        assign w_diff = $signed({1'b0, w_cb[8*c +: 8]}) - $signed({1'b0, w_ca[8*c +: 8]});

        always_ff @(posedge i_clk) begin
            r_c_a[c]  <= w_ca[8*c +: 8];
            r_c_pr[c] <= w_diff * $signed({1'b0, w_f});
        end
    end

    // color stage b: round, add and pack; expired words are zeroed
    logic [31:0] w_color;

    always_comb begin
        w_color = '0;
        for (int c = 0; c < 4; c++) begin
            w_color[8*c +: 8] = r_c_a[c] + 8'((r_c_pr[c] + 27'sd32768) >>> 16);
        end
    end

    t_motion w_fin;
    assign w_fin = r_mdly[MDLY];

    logic signed [19:0] r_o_px, r_o_py, r_o_sz, r_o_sp, r_o_sn;
    logic [15:0]        r_o_hd, r_o_age, r_o_life;
    logic [31:0]        r_o_col;
    logic               r_o_exp;

    always_ff @(posedge i_clk) begin
        r_o_age  <= w_fin.age;
        r_o_life <= w_fin.life;
        r_o_exp  <= w_fin.expired;
        if (w_fin.expired) begin
            r_o_px  <= '0;
            r_o_py  <= '0;
            r_o_sz  <= '0;
            r_o_hd  <= '0;
            r_o_sp  <= '0;
            r_o_sn  <= '0;
            r_o_col <= '0;
        end else begin
            r_o_px  <= w_fin.pos_x;
            r_o_py  <= w_fin.pos_y;
            r_o_sz  <= w_fin.size;
            r_o_hd  <= w_fin.heading;
            r_o_sp  <= w_fin.speed;
            r_o_sn  <= w_fin.spin;
            r_o_col <= w_color;
        end
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_new_pos_x    = r_o_px;
    assign o_new_pos_y    = r_o_py;
    assign o_new_size     = r_o_sz;
    assign o_new_heading  = r_o_hd;
    assign o_new_speed    = r_o_sp;
    assign o_new_spin     = r_o_sn;
    assign o_new_age      = r_o_age;
    assign o_lifetime_out = r_o_life;
    assign o_color_out    = r_o_col;
    assign o_expired      = r_o_exp;

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LAT) o_valid)
        else $error("accepted word did not reach the output");

    // expired words carry no motion or color
    a_expired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_expired) |-> (o_new_size == '0 && o_color_out == '0
                                    && o_new_pos_x == '0 && o_new_heading == '0))
        else $error("expired word has nonzero fields");

    // a live particle is younger than its lifetime
    a_live_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_expired) |-> (o_new_age < o_lifetime_out))
        else $error("live word with age at or past lifetime");

    // expiry seen at stage two matches the age compare at the output
    a_exp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_expired == (o_new_age >= o_lifetime_out)))
        else $error("expiry flag disagrees with age and lifetime");

endmodule

FILE: tb/particle_state_update_top_tb.sv
// testbench for the particle state update block: random and directed words against a predictor
module particle_state_update_top_tb;
    import pstu_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int LATENCY   = 21;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [11:0]        dt;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] sz;
        logic [15:0]        hd;
        logic signed [19:0] sp;
        logic signed [19:0] sn;
        logic [15:0]        age;
        logic [15:0]        life;
    } t_particle;

    typedef struct packed {
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] sz;
        logic [15:0]        hd;
        logic signed [19:0] sp;
        logic signed [19:0] sn;
        logic [15:0]        age;
        logic [15:0]        life;
        logic [31:0]        color;
        logic               expired;
    } t_update;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_particle   drv;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        o_valid;
    t_update     got;

    // predictor copy of the registers
    longint      rate_size, rate_speed, rate_heading, rate_spin;
    logic [31:0] col_birth, col_middle, col_death;
    longint      sine_lut [DEPTH];

    t_particle   pending_words [$];
    t_update     expected_updates [$];
    int          mismatches;
    int          cycle_count;
    int          gap_left;

    particle_state_update_top #(.TRIG_TABLE_DEPTH(DEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_time_step(drv.dt), .i_pos_x(drv.px), .i_pos_y(drv.py), .i_size_now(drv.sz),
        .i_heading(drv.hd), .i_speed_now(drv.sp), .i_spin(drv.sn), .i_age(drv.age),
        .i_lifetime(drv.life), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .o_valid(o_valid), .o_new_pos_x(got.px),
        .o_new_pos_y(got.py), .o_new_size(got.sz), .o_new_heading(got.hd),
        .o_new_speed(got.sp), .o_new_spin(got.sn), .o_new_age(got.age),
        .o_lifetime_out(got.life), .o_color_out(got.color), .o_expired(got.expired)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // division by a power of two, rounding half up
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip20(input longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // quarter wave sine in Q1.14, taylor series evaluated in Q30
    function automatic longint quarter_wave(input longint m);
        longint divs [5];
        longint theta, t2, s;
        divs = '{110, 72, 42, 20, 6};
        theta = m * PIHALF_Q30 / DEPTH;
        t2 = (theta * theta) >>> 30;
        s = ONE_Q30;
        for (int k = 0; k < 5; k++) s = ONE_Q30 - ((t2 * s) >>> 30) / divs[k];
        s = rnd_shift((theta * s) >>> 30, 16);
        return (s > 16384) ? 16384 : s;
    endfunction

    function automatic logic [31:0] mix_color(input logic [31:0] a, input logic [31:0] b,
                                              input longint f);
        logic [31:0] res;
        longint ca, cb;
        res = '0;
        for (int sh = 0; sh < 32; sh += 8) begin
            ca = (a >> sh) & 8'hFF;
            cb = (b >> sh) & 8'hFF;
            res[sh +: 8] = 8'(ca + rnd_shift((cb - ca) * f, 16));
        end
        return res;
    endfunction

    function automatic t_update advance_particle(input t_particle p);
        t_update u;
        longint dt, nage, nsp, nhd, idx, sv, cv, t;
        u = '0;
        dt = p.dt;
        nage = longint'(p.age) + dt;
        if (nage > 65535) nage = 65535;
        u.age  = nage[15:0];
        u.life = p.life;
        if (nage >= p.life) begin
            u.expired = 1'b1;
            return u;
        end
        u.sz = clip20(longint'(p.sz) + rnd_shift(rate_size * dt, 12));
        nsp  = clip20(longint'(p.sp) + rnd_shift(rate_speed * dt, 12));
        u.sp = nsp;
        nhd  = (longint'(p.hd) + rnd_shift(rate_heading * dt, 12)) & 16'hFFFF;
        u.hd = nhd[15:0];
        u.sn = clip20(longint'(p.sn) + rnd_shift(rate_spin * dt, 12));
        idx  = (nhd * DEPTH) >>> 16;
        sv   = sine_lut[idx];
        cv   = sine_lut[(idx + DEPTH / 4) % DEPTH];
        u.px = clip20(longint'(p.px) + rnd_shift(nsp * dt * cv, 26));
        u.py = clip20(longint'(p.py) + rnd_shift(nsp * dt * sv, 26));
        t = (nage << 16) / p.life;
        if (t < 32768) u.color = mix_color(col_birth, col_middle, t * 2);
        else u.color = mix_color(col_middle, col_death, (t - 32768) * 2);
        return u;
    endfunction

    // config write, only issued while nothing is in flight
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SIZE_RATE:    rate_size    = longint'(signed'(val[19:0]));
            CFG_SPEED_RATE:   rate_speed   = longint'(signed'(val[19:0]));
            CFG_HEADING_RATE: rate_heading = longint'(signed'(val[23:0]));
            CFG_SPIN_RATE:    rate_spin    = longint'(signed'(val[19:0]));
            CFG_BIRTH_COLOR:  col_birth    = val;
            CFG_MIDDLE_COLOR: col_middle   = val;
            default:          col_death    = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic drain;
        while (pending_words.size() != 0 || expected_updates.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_particle rand_particle(input bit live);
        t_particle p;
        p.dt  = $urandom;
        p.px  = $urandom;
        p.py  = $urandom;
        p.sz  = $urandom;
        p.hd  = $urandom;
        p.sp  = $urandom;
        p.sn  = $urandom;
        p.life = $urandom_range(65535, 1);
        if (live) begin
            // mostly live particles so the motion and color paths are exercised
            p.age = $urandom_range(p.life - 1, 0);
            if ($urandom_range(3, 0) == 0) p.dt = $urandom_range(15, 0);
            if ($urandom_range(3, 0) == 0) begin
                p.sp = $urandom_range(4095, 0);
                if ($urandom_range(1, 0)) p.sp = -p.sp;
            end
        end else begin
            p.age = $urandom;
        end
        return p;
    endfunction

    function automatic t_particle mk(input logic [11:0] dt, input longint px, input longint sz,
                                     input logic [15:0] hd, input longint sp,
                                     input logic [15:0] age, input logic [15:0] life);
        t_particle p;
        p.dt = dt; p.px = px; p.py = -px; p.sz = sz; p.hd = hd; p.sp = sp; p.sn = -sz;
        p.age = age; p.life = life;
        return p;
    endfunction

    // randomized register set: extremes now and then
    task automatic random_regs;
        logic [31:0] v [4];
        for (int r = 0; r < 4; r++) begin
            case ($urandom_range(3, 0))
                0: v[r] = 32'h0007FFFF;
                1: v[r] = 32'h00080000;
                default: v[r] = $urandom;
            endcase
        end
        write_reg(CFG_SIZE_RATE, v[0]);
        write_reg(CFG_SPEED_RATE, v[1]);
        write_reg(CFG_HEADING_RATE, ($urandom_range(1, 0)) ? 32'h007FFFFF : $urandom);
        write_reg(CFG_SPIN_RATE, v[3]);
        write_reg(CFG_BIRTH_COLOR, $urandom);
        write_reg(CFG_MIDDLE_COLOR, $urandom);
        write_reg(CFG_DEATH_COLOR, $urandom);
    endtask

    // driver: one word per start, with random gaps between words
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            if (gap_left == 0 && pending_words.size() > 0) begin
                drv <= pending_words[0];
                expected_updates.push_back(advance_particle(pending_words.pop_front()));
                gap_left <= ($urandom_range(2, 0) == 0) ? $urandom_range(5, 0) : 0;
            end else begin
                start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
            start <= 1'b1;
            drv   <= pending_words[0];
            expected_updates.push_back(advance_particle(pending_words.pop_front()));
            gap_left <= ($urandom_range(2, 0) == 0) ? $urandom_range(5, 0) : 0;
        end
    end

    // monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_update e;
        if (i_rst_n && o_valid) begin
            if (expected_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                e = expected_updates.pop_front();
                if (got !== e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp px %h py %h sz %h hd %h sp %h sn %h", e.px, e.py,
                                 e.sz, e.hd, e.sp, e.sn);
                        $display("         got px %h py %h sz %h hd %h sp %h sn %h", got.px,
                                 got.py, got.sz, got.hd, got.sp, got.sn);
                        $display("  exp age %h life %h col %h exp %b / got %h %h %h %b",
                                 e.age, e.life, e.color, e.expired, got.age, got.life,
                                 got.color, got.expired);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycle_count = 0;
        gap_left = 0;
        start = 1'b0;
        drv = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SIZE_RATE;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        rate_size = 256; rate_speed = 0; rate_heading = 0; rate_spin = 0;
        col_birth = 32'hFFFFFFFF; col_middle = 32'hFFFFFF80; col_death = 32'hFFFFFF00;
        for (int i = 0; i < DEPTH; i++) begin
            longint r;
            r = (4 * i) % DEPTH;
            case ((4 * i) / DEPTH)
                0: sine_lut[i] = quarter_wave(r);
                1: sine_lut[i] = quarter_wave(DEPTH - r);
                2: sine_lut[i] = -quarter_wave(r);
                default: sine_lut[i] = -quarter_wave(DEPTH - r);
            endcase
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, field extremes, expiry cases, half-life boundary
        pending_words.push_back(mk(12'd0, 0, 0, 16'h0000, 0, 16'd0, 16'd1));
        pending_words.push_back(mk(12'hFFF, 524287, 524287, 16'hFFFF, 524287, 16'd0, 16'hFFFF));
        pending_words.push_back(mk(12'hFFF, -524288, -524288, 16'h4000, -524288, 16'd0, 16'hFFFF));
        pending_words.push_back(mk(12'hFFF, 1000, 5, 16'h8000, 524287, 16'd100, 16'hFFFF));
        pending_words.push_back(mk(12'hFFF, -1000, 5, 16'hC000, -524288, 16'd100, 16'hFFFF));
        pending_words.push_back(mk(12'd1, 5, 5, 16'h2000, 256, 16'd99, 16'd100));
        pending_words.push_back(mk(12'd0, 5, 5, 16'h2000, 256, 16'd100, 16'd100));
        pending_words.push_back(mk(12'hFFF, 5, 5, 16'h2000, 256, 16'hFFFF, 16'hFFFF));
        pending_words.push_back(mk(12'hFFF, 5, 5, 16'h2000, 256, 16'hFFF0, 16'hFFFF));
        pending_words.push_back(mk(12'd0, 5, 5, 16'h1234, 256, 16'd50, 16'd100));
        pending_words.push_back(mk(12'd0, 5, 5, 16'h1234, 256, 16'd49, 16'd100));
        pending_words.push_back(mk(12'd0, 5, 5, 16'h00FF, 256, 16'd0, 16'd2));
        drain();

        random_regs();
        write_reg(CFG_SIZE_RATE, 32'h0007FFFF);
        write_reg(CFG_SPEED_RATE, 32'h00080000);
        write_reg(CFG_HEADING_RATE, 32'h00800000);
        write_reg(CFG_SPIN_RATE, 32'h0007FFFF);
        write_reg(CFG_BIRTH_COLOR, 32'h00000000);
        write_reg(CFG_MIDDLE_COLOR, 32'hFFFFFFFF);
        write_reg(CFG_DEATH_COLOR, 32'h00FF00FF);
        pending_words.push_back(mk(12'hFFF, 524287, 524287, 16'hFFFF, 524287, 16'd0, 16'hFFFF));
        pending_words.push_back(mk(12'hFFF, -524288, -524288, 16'd0, -524288, 16'd0, 16'hFFFF));
        for (int k = 0; k < 8; k++) pending_words.push_back(rand_particle(1));

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            random_regs();
            for (int k = 0; k < 205; k++)
                pending_words.push_back(rand_particle($urandom_range(9, 0) != 0));
        end
        drain();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
